[rtl/cll_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_pkg: shared types and codes of the command line lexer
// Result record, queue entry, and the token-type and error codes.
// ----------------------------------------------------------------------------
package cll_pkg;

  // Result kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Token types.
  localparam logic [2:0] TT_IDENT  = 3'd0;
  localparam logic [2:0] TT_STRING = 3'd1;
  localparam logic [2:0] TT_NUMBER = 3'd2;
  localparam logic [2:0] TT_ERROR  = 3'd3;
  localparam logic [2:0] TT_END    = 3'd4;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNTERM_STR = 3'd1;
  localparam logic [2:0] ERR_LONE_MINUS = 3'd2;
  localparam logic [2:0] ERR_MULTI_PT   = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN    = 3'd4;

  typedef struct packed {
    logic       kind;
    logic [2:0] ttype;
    logic [2:0] err;
    logic [7:0] ch;
  } res_t;

  // One queue entry holds all results that one character causes.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } entry_t;

endpackage

[rtl/cll_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_front: character classifier and lexer state
// Accepts one character per cycle unless stalled, updates the lexer state and pushes the
// results that the character causes into the queue as one entry.
// ----------------------------------------------------------------------------
module cll_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      char_code,
  input  logic            q_full,
  output logic            push,
  output cll_pkg::entry_t push_entry
);
  import cll_pkg::*;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  localparam logic [1:0] QK_NONE   = 2'd0;
  localparam logic [1:0] QK_SINGLE = 2'd1;
  localparam logic [1:0] QK_DOUBLE = 2'd2;
  localparam logic [1:0] QK_BTICK  = 2'd3;

  typedef enum logic [3:0] {
    M_IDLE   = 4'b0001,
    M_IDENT  = 4'b0010,
    M_NUMBER = 4'b0100,
    M_STRING = 4'b1000
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [1:0] quote;
    logic [1:0] points;
    logic       minus;
    logic       has;
    res_t       res;
  } idle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return is_digit(c) || (c == CH_POINT);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
           is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic res_t mk(input logic k, input logic [2:0] t, input logic [2:0] e,
                              input logic [7:0] c);
    res_t r;
    r.kind  = k;
    r.ttype = t;
    r.err   = e;
    r.ch    = c;
    return r;
  endfunction

  function automatic logic [1:0] bump(input logic [1:0] p, input logic [7:0] c);
    return ((c == CH_POINT) && (p < 2'd2)) ? p + 2'd1 : p;
  endfunction

  function automatic logic [7:0] quote_char(input logic [1:0] q);
    logic [7:0] r;
    case (q)
      QK_SINGLE: r = CH_SQUOTE;
      QK_DOUBLE: r = CH_DQUOTE;
      QK_BTICK:  r = CH_BTICK;
      default:   r = CH_NUL;
    endcase
    return r;
  endfunction

  // Handling of a character as if the lexer were idle.
  function automatic idle_t start_idle(input logic [7:0] c);
    idle_t s;
    s.mode   = M_IDLE;
    s.quote  = QK_NONE;
    s.points = 2'd0;
    s.minus  = 1'b0;
    s.has    = 1'b0;
    s.res    = '0;
    if (c == CH_NUL) begin
      s.has = 1'b1;
      s.res = mk(KIND_DONE, TT_END, ERR_NONE, CH_NUL);
    end else if (is_blank(c) || (c == CH_COMMA)) begin
      s.has = 1'b0;
    end else if (is_num(c)) begin
      s.mode   = M_NUMBER;
      s.points = bump(2'd0, c);
      s.has    = 1'b1;
      s.res    = mk(KIND_CHAR, TT_NUMBER, ERR_NONE, c);
    end else if (c == CH_MINUS) begin
      s.mode  = M_NUMBER;
      s.minus = 1'b1;
    end else if (is_word(c)) begin
      s.mode = M_IDENT;
      s.has  = 1'b1;
      s.res  = mk(KIND_CHAR, TT_IDENT, ERR_NONE, c);
    end else if (c == CH_SQUOTE) begin
      s.mode  = M_STRING;
      s.quote = QK_SINGLE;
    end else if (c == CH_DQUOTE) begin
      s.mode  = M_STRING;
      s.quote = QK_DOUBLE;
    end else if (c == CH_BTICK) begin
      s.mode  = M_STRING;
      s.quote = QK_BTICK;
    end else begin
      s.has = 1'b1;
      s.res = mk(KIND_DONE, TT_ERROR, ERR_UNKNOWN, c);
    end
    return s;
  endfunction

  mode_t      mode, mode_next;
  logic [1:0] quote, quote_next;
  logic [1:0] points, points_next;
  logic       minus, minus_next;
  idle_t      idl;
  logic       use_idle;
  logic       accept;
  entry_t     ent;

  assign in_stall = q_full | rst;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    idl         = start_idle(char_code);
    mode_next   = mode;
    quote_next  = quote;
    points_next = points;
    minus_next  = minus;
    use_idle    = 1'b0;
    ent         = '0;
    unique case (mode)
      M_IDENT: begin
        if (is_word(char_code)) begin
          ent.cnt = 2'd1;
          ent.r0  = mk(KIND_CHAR, TT_IDENT, ERR_NONE, char_code);
        end else begin
          ent.r0   = mk(KIND_DONE, TT_IDENT, ERR_NONE, CH_NUL);
          use_idle = 1'b1;
        end
      end
      M_NUMBER: begin
        if (minus) begin
          if (is_num(char_code)) begin
            minus_next  = 1'b0;
            points_next = bump(points, char_code);
            ent.cnt     = 2'd2;
            ent.r0      = mk(KIND_CHAR, TT_NUMBER, ERR_NONE, CH_MINUS);
            ent.r1      = mk(KIND_CHAR, TT_NUMBER, ERR_NONE, char_code);
          end else begin
            ent.r0   = mk(KIND_DONE, TT_ERROR, ERR_LONE_MINUS, CH_NUL);
            use_idle = 1'b1;
          end
        end else if (is_num(char_code)) begin
          points_next = bump(points, char_code);
          ent.cnt     = 2'd1;
          ent.r0      = mk(KIND_CHAR, TT_NUMBER, ERR_NONE, char_code);
        end else begin
          if (points >= 2'd2) begin
            ent.r0 = mk(KIND_DONE, TT_ERROR, ERR_MULTI_PT, CH_NUL);
          end else begin
            ent.r0 = mk(KIND_DONE, TT_NUMBER, ERR_NONE, CH_NUL);
          end
          use_idle = 1'b1;
        end
      end
      M_STRING: begin
        if (char_code == CH_NUL) begin
          ent.r0   = mk(KIND_DONE, TT_ERROR, ERR_UNTERM_STR, CH_NUL);
          use_idle = 1'b1;
        end else if (char_code == quote_char(quote)) begin
          ent.cnt     = 2'd1;
          ent.r0      = mk(KIND_DONE, TT_STRING, ERR_NONE, CH_NUL);
          mode_next   = M_IDLE;
          quote_next  = QK_NONE;
          points_next = 2'd0;
          minus_next  = 1'b0;
        end else begin
          ent.cnt = 2'd1;
          ent.r0  = mk(KIND_CHAR, TT_STRING, ERR_NONE, char_code);
        end
      end
      default: begin
        ent.cnt     = {1'b0, idl.has};
        ent.r0      = idl.res;
        mode_next   = idl.mode;
        quote_next  = idl.quote;
        points_next = idl.points;
        minus_next  = idl.minus;
      end
    endcase
    // A token ended: its completion comes first, then the character is lexed from idle.
    if (use_idle) begin
      ent.cnt     = idl.has ? 2'd2 : 2'd1;
      ent.r1      = idl.res;
      mode_next   = idl.mode;
      quote_next  = idl.quote;
      points_next = idl.points;
      minus_next  = idl.minus;
    end
  end

  assign push       = accept && (ent.cnt != 2'd0);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      quote  <= QK_NONE;
      points <= 2'd0;
      minus  <= 1'b0;
    end else if (accept) begin
      mode   <= mode_next;
      quote  <= quote_next;
      points <= points_next;
      minus  <= minus_next;
    end
  end

endmodule

[rtl/cll_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_queue: entry queue between classifier and result sequencer
// Small flip-flop FIFO with push and pop in the same cycle.
// ----------------------------------------------------------------------------
module cll_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cll_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output cll_pkg::entry_t head
);
  import cll_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        mem [DEPTH];
  logic [IW-1:0] wr_ptr;
  logic [IW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count out of range");

endmodule

[rtl/cll_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_back: result sequencer
// Unpacks each queue entry into one or two results through an output register.
// ----------------------------------------------------------------------------
module cll_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  cll_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            result_kind,
  output logic [2:0]      token_type,
  output logic [2:0]      error_code,
  output logic [7:0]      char_value,
  output logic            last
);
  import cll_pkg::*;

  logic sel;      // set while the second result of the head entry is next
  logic load;
  logic tail;
  res_t cur;

  assign load = head_valid && (!out_valid || !out_stall);
  assign tail = sel || (head.cnt == 2'd1);
  assign pop  = load && tail;
  assign cur  = sel ? head.r1 : head.r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        out_valid <= head_valid;
      end
      if (load) begin
        sel <= !tail;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_kind <= cur.kind;
      token_type  <= cur.ttype;
      error_code  <= cur.err;
      char_value  <= cur.ch;
      last        <= tail;
    end
  end

  a_entry_nonempty: assert property (@(posedge clk) disable iff (rst)
      head_valid |-> head.cnt != 2'd0)
    else $error("empty entry in queue");
  a_second_pending: assert property (@(posedge clk) disable iff (rst)
      sel |-> head_valid && head.cnt == 2'd2)
    else $error("second result pending without a two-result entry");
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
      load && !tail |=> sel)
    else $error("second result not scheduled");

endmodule

[rtl/command_line_lexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_lexer: streaming lexer for command-line text
// Splits a character stream into identifier, number and string tokens.
// ----------------------------------------------------------------------------
// Results: each result passes through the entry queue and then the output register; a
//   second result of the same character follows the first on the output.
// Rate: one character per cycle unless in_stall is set; the output moves one result per
//   cycle while out_stall is low, so a character that causes two results holds it for both.
// The entry queue (QUEUE_DEPTH) absorbs such bursts; input stalls when it fills or in reset.
// Reset: lexer idle, queue and output register empty; usable the cycle after.
// ----------------------------------------------------------------------------
//
// Structure:
//   cll_front  classifies each character against the lexer mode (idle,
//              identifier, number, quoted string), keeps the quote kind, the
//              saturating decimal-point count and the pending-minus flag, and
//              packs every result that the character causes into one entry.
//   cll_queue  holds entries so that the front keeps taking characters while
//              the output side is stalled.
//   cll_back   replays each entry as one or two results and marks the final
//              one of each character with last.
//
// Each request on the input channel carries one byte; byte zero ends the text
// and yields an end token. A character that ends an identifier or number first
// completes that token and is then lexed as if the lexer were idle, so at most
// two results arise from one character.
module command_line_lexer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       result_kind,
  output logic [2:0] token_type,
  output logic [2:0] error_code,
  output logic [7:0] char_value,
  output logic       last
);
  import cll_pkg::*;

  logic   q_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   head_valid;
  entry_t head;

  // Front: lexer state and classification.
  cll_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_code  (char_code),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decoupling queue: one entry per character that produced any result.
  cll_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: result sequencing and output register.
  cll_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .token_type  (token_type),
    .error_code  (error_code),
    .char_value  (char_value),
    .last        (last)
  );

endmodule
